@@ rtl/assert_macros.svh @@
// Assertion macros shared by the list unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define IIDL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define IIDL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IIDL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/iidl_pkg.sv @@
// Package with the shared constants and types of the list unit.
`timescale 1ns / 1ps

package iidl_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int CMD_W = 4;
	localparam int POS_W = 6;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd0;
	localparam logic [CMD_W-1:0] CMD_INS_FIRST = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_INS_LAST  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 4'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_WRITE     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_READ      = 4'd8;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	// Read address selection.
	localparam logic [1:0] RD_PTR_M1 = 2'd0;
	localparam logic [1:0] RD_PTR_P1 = 2'd1;
	localparam logic [1:0] RD_AT     = 2'd2;

	typedef struct packed {
		logic            load_in;
		logic            ptr_from_fill;
		logic            ptr_from_at;
		logic            ptr_dec;
		logic            ptr_inc;
		logic            rd_en;
		logic [1:0]      rd_sel;
		logic            wr_en;
		logic            wr_put;
		logic            fill_clr;
		logic            fill_inc;
		logic            fill_dec;
		logic            out_load;
		logic            out_read;
		logic [ST_W-1:0] out_status;
	} dp_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             pos_gt_fill;
		logic             pos_ge_fill;
		logic             at_lt_fill;
		logic             at_p1_lt_fill;
		logic             up_more;
		logic             down_more;
	} dp_sts_t;

endpackage

@@ rtl/iidl_dpath.sv @@
// Datapath of the list unit: entry memory, count, move pointer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iidl_dpath #(
	parameter int CAPACITY   = iidl_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = iidl_pkg::ELEM_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  iidl_pkg::dp_ctl_t                ctl,
	output iidl_pkg::dp_sts_t                sts,
	input  logic [iidl_pkg::CMD_W-1:0]       cmd,
	input  logic [iidl_pkg::POS_W-1:0]       position,
	input  logic [ELEM_WIDTH-1:0]            elem_in,
	output logic [iidl_pkg::ST_W-1:0]        status,
	output logic [ELEM_WIDTH-1:0]            elem_out,
	output logic [$clog2(CAPACITY+1)-1:0]    fill_count,
	output logic                             now_empty,
	output logic                             now_full
);
	import iidl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

	logic [ELEM_WIDTH-1:0] mem [CAPACITY];

	logic [CMD_W-1:0]      cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] elem_q;
	logic [FW-1:0]         fill_q;
	logic [AW-1:0]         ptr_q;
	logic [ELEM_WIDTH-1:0] rd_data_q;

	logic [ST_W-1:0]       status_q;
	logic [ELEM_WIDTH-1:0] elem_out_q;
	logic [FW-1:0]         fill_out_q;
	logic                  empty_q;
	logic                  full_q;

	logic [CW-1:0]         at_w;
	logic [CW-1:0]         fill_w;
	logic [CW-1:0]         pos_w;
	logic [CW-1:0]         ptr_w;
	logic [AW-1:0]         at_a;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic                  full_now;

	assign fill_w   = CW'(fill_q);
	assign pos_w    = CW'(pos_q);
	assign ptr_w    = CW'(ptr_q);
	assign full_now = (fill_q == FW'(CAPACITY));

	// The list index that the command works on.
	always_comb begin
		case (cmd_q)
			CMD_INS_FIRST, CMD_DEL_FIRST: at_w = '0;
			CMD_INS_LAST:                 at_w = fill_w;
			default:                      at_w = pos_w;
		endcase
	end

	// Every successful command has its index below the capacity.
	assign at_a = at_w[AW-1:0];

	assign sts.cmd           = cmd_q;
	assign sts.full          = full_now;
	assign sts.empty         = (fill_q == '0);
	assign sts.pos_gt_fill   = (pos_w > fill_w);
	assign sts.pos_ge_fill   = (pos_w >= fill_w);
	assign sts.at_lt_fill    = (at_w < fill_w);
	assign sts.at_p1_lt_fill = ((at_w + CW'(1)) < fill_w);
	assign sts.up_more       = (ptr_w > (at_w + CW'(1)));
	assign sts.down_more     = ((ptr_w + CW'(2)) < fill_w);

	always_comb begin
		case (ctl.rd_sel)
			RD_PTR_M1: rd_addr = ptr_q - AW'(1);
			RD_PTR_P1: rd_addr = ptr_q + AW'(1);
			RD_AT:     rd_addr = at_a;
			default:   rd_addr = ptr_q;
		endcase
	end

	assign wr_addr = ctl.wr_put ? at_a : ptr_q;
	assign wr_data = ctl.wr_put ? elem_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= cmd;
			pos_q  <= position;
			elem_q <= elem_in;
		end
		if (ctl.ptr_from_fill) begin
			ptr_q <= fill_q[AW-1:0];
		end else if (ctl.ptr_from_at) begin
			ptr_q <= at_a;
		end else if (ctl.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (ctl.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (ctl.out_load) begin
			status_q   <= ctl.out_status;
			elem_out_q <= ctl.out_read ? rd_data_q : '0;
			fill_out_q <= fill_q;
			empty_q    <= (fill_q == '0);
			full_q     <= full_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.fill_clr) begin
			fill_q <= '0;
		end else if (ctl.fill_inc) begin
			fill_q <= fill_q + FW'(1);
		end else if (ctl.fill_dec) begin
			fill_q <= fill_q - FW'(1);
		end
	end

	assign status     = status_q;
	assign elem_out   = elem_out_q;
	assign fill_count = fill_out_q;
	assign now_empty  = empty_q;
	assign now_full   = full_q;

	`IIDL_ASSERT(a_fill_bound, fill_q <= FW'(CAPACITY), "entry count above capacity")
	`IIDL_ASSERT_IMP(a_wr_in_list, ctl.wr_en, CW'(wr_addr) <= fill_w, "write beyond list end")
	`IIDL_ASSERT_NXT(a_fill_hold, !ctl.fill_clr && !ctl.fill_inc && !ctl.fill_dec, $stable(fill_q), "count moved without a command")

endmodule

@@ rtl/iidl_ctrl.sv @@
// Controller of the list unit: command decode and the entry move sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iidl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output iidl_pkg::dp_ctl_t ctl,
	input  iidl_pkg::dp_sts_t sts
);
	import iidl_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SU_RD = 4'd2;
	localparam logic [3:0] S_SU_WR = 4'd3;
	localparam logic [3:0] S_PUT   = 4'd4;
	localparam logic [3:0] S_SD_RD = 4'd5;
	localparam logic [3:0] S_SD_WR = 4'd6;
	localparam logic [3:0] S_DEC   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]      state_q, state_d;
	logic [ST_W-1:0] st_q, st_d;
	logic            rd_q, rd_d;
	logic            grow_q, grow_d;
	logic            out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		st_d    = st_q;
		rd_d    = rd_q;
		grow_d  = grow_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				st_d    = ST_OK;
				rd_d    = 1'b0;
				grow_d  = 1'b0;
				state_d = S_DONE;
				case (sts.cmd)
					CMD_CLEAR: begin
						ctl.fill_clr = 1'b1;
					end
					CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
						if (sts.full) begin
							st_d = ST_FULL;
						end else if (sts.cmd == CMD_INS_AT && sts.pos_gt_fill) begin
							st_d = ST_RANGE;
						end else begin
							grow_d = 1'b1;
							if (sts.at_lt_fill) begin
								ctl.ptr_from_fill = 1'b1;
								state_d           = S_SU_RD;
							end else begin
								state_d = S_PUT;
							end
						end
					end
					CMD_DEL_FIRST, CMD_DEL_AT: begin
						if (sts.empty) begin
							st_d = ST_EMPTY;
						end else if (sts.cmd == CMD_DEL_AT && sts.pos_ge_fill) begin
							st_d = ST_RANGE;
						end else if (sts.at_p1_lt_fill) begin
							ctl.ptr_from_at = 1'b1;
							state_d         = S_SD_RD;
						end else begin
							state_d = S_DEC;
						end
					end
					CMD_DEL_LAST: begin
						if (sts.empty) begin
							st_d = ST_EMPTY;
						end else begin
							state_d = S_DEC;
						end
					end
					CMD_WRITE: begin
						if (!sts.pos_ge_fill) begin
							state_d = S_PUT;
						end else if (!sts.pos_gt_fill) begin
							// Writing one past the end appends.
							if (sts.full) begin
								st_d = ST_FULL;
							end else begin
								grow_d  = 1'b1;
								state_d = S_PUT;
							end
						end else begin
							st_d = ST_RANGE;
						end
					end
					CMD_READ: begin
						if (sts.empty) begin
							st_d = ST_EMPTY;
						end else if (sts.pos_ge_fill) begin
							st_d = ST_RANGE;
						end else begin
							rd_d       = 1'b1;
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = RD_AT;
						end
					end
					default: begin
					end
				endcase
			end
			S_SU_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_PTR_M1;
				state_d    = S_SU_WR;
			end
			S_SU_WR: begin
				ctl.wr_en   = 1'b1;
				ctl.ptr_dec = 1'b1;
				state_d     = sts.up_more ? S_SU_RD : S_PUT;
			end
			S_PUT: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_put   = 1'b1;
				ctl.fill_inc = grow_q;
				state_d      = S_DONE;
			end
			S_SD_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_PTR_P1;
				state_d    = S_SD_WR;
			end
			S_SD_WR: begin
				ctl.wr_en   = 1'b1;
				ctl.ptr_inc = 1'b1;
				state_d     = sts.down_more ? S_SD_RD : S_DEC;
			end
			S_DEC: begin
				ctl.fill_dec = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// The result register frees up in the same cycle its transaction completes.
				if (!out_valid_q || !out_stall) begin
					ctl.out_load   = 1'b1;
					ctl.out_status = st_q;
					ctl.out_read   = rd_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			rd_q        <= 1'b0;
			grow_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rd_q    <= rd_d;
			grow_q  <= grow_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`IIDL_ASSERT_NXT(a_accept_to_check, in_valid && !in_stall, state_q == S_CHECK, "accepted command not decoded")
	`IIDL_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside completion")
	`IIDL_ASSERT_NXT(a_su_loop, state_q == S_SU_WR, state_q == S_SU_RD || state_q == S_PUT, "shift up loop left early")
	`IIDL_ASSERT_IMP(a_read_ok, rd_q && state_q == S_DONE, st_q == ST_OK, "read data flagged on failed command")

endmodule

@@ rtl/indexed_insert_delete_list_unit.sv @@
// Top level of the indexed insert/delete list unit.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY elements held in one memory with a registered read
// port and a write port. One command is taken at a time; each returns one result
// transaction. An insert moves the entries from its index to the end up one place
// (the count minus the index entries), and a delete moves the entries behind its index
// down one place (the count minus the index minus one entries), before the element is
// written or the count lowered. Each moved entry costs one memory read and one memory
// write in consecutive cycles. A command may be accepted while the previous result
// still waits on the output; a result that is held by the output stall delays the
// return to idle.
module indexed_insert_delete_list_unit #(
	parameter int CAPACITY   = iidl_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = iidl_pkg::ELEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iidl_pkg::CMD_W-1:0]    cmd,
	input  logic [iidl_pkg::POS_W-1:0]    position,
	input  logic [ELEM_WIDTH-1:0]         elem_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [iidl_pkg::ST_W-1:0]     status,
	output logic [ELEM_WIDTH-1:0]         elem_out,
	output logic [$clog2(CAPACITY+1)-1:0] fill_count,
	output logic                          now_empty,
	output logic                          now_full
);
	import iidl_pkg::*;

	dp_ctl_t dp_ctl;
	dp_sts_t dp_sts;

	iidl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (dp_ctl),
		.sts       (dp_sts)
	);

	iidl_dpath #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dp_ctl),
		.sts        (dp_sts),
		.cmd        (cmd),
		.position   (position),
		.elem_in    (elem_in),
		.status     (status),
		.elem_out   (elem_out),
		.fill_count (fill_count),
		.now_empty  (now_empty),
		.now_full   (now_full)
	);

endmodule
